### rtl/core/batb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// batb_pkg
// Shared types, register codes and helpers for the box affine bounds block.
// ============================================================================
package batb_pkg;

    localparam int CoordW  = 32;
    localparam int CoefW   = 16;
    localparam int RowW    = 3 * CoefW;
    localparam int ProdW   = CoefW + CoordW;
    localparam int SumW    = ProdW + 2;
    localparam int FracSh  = 14;
    localparam int BiasW   = SumW - FracSh + 1;
    localparam int Stages  = 4;
    localparam int AddrW   = 6;
    localparam int DataW   = 64;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [RowW-1:0]          row_t;
    typedef logic [2:0]               reg_idx_t;

    // Register indexes (byte address is 8 * index)
    localparam reg_idx_t RegRowX   = 3'd0;
    localparam reg_idx_t RegRowY   = 3'd1;
    localparam reg_idx_t RegRowZ   = 3'd2;
    localparam reg_idx_t RegShiftX = 3'd3;
    localparam reg_idx_t RegShiftY = 3'd4;
    localparam reg_idx_t RegShiftZ = 3'd5;

    localparam row_t   RowXReset  = 48'h0000_4000_0000;
    localparam row_t   RowYReset  = 48'h0000_0000_4000;
    localparam row_t   RowZReset  = 48'h0001_0000_0000;

    localparam coord_t CoordMax = 32'sh7FFF_FFFF;
    localparam coord_t CoordMin = -32'sh7FFF_FFFF - 32'sd1;

    // Per-stage load enables and valid bits of the datapath
    typedef struct packed {
        logic [Stages-1:0] load;
        logic [Stages-1:0] valid;
    } stage_ctl_t;

    function automatic coord_t sat_coord(input logic signed [BiasW-1:0] v);
        coord_t r;
        if (v > BiasW'(CoordMax))
            r = CoordMax;
        else if (v < BiasW'(CoordMin))
            r = CoordMin;
        else
            r = CoordW'(v);
        return r;
    endfunction

endpackage

### rtl/core/batb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// batb_regs
// APB register file: three matrix rows and three translations.
// ============================================================================
module batb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [batb_pkg::AddrW-1:0]   paddr,
    input  wire logic [batb_pkg::DataW-1:0]   pwdata,
    output logic      [batb_pkg::DataW-1:0]   prdata,
    output logic                              pready,
    output batb_pkg::row_t                    row_x,
    output batb_pkg::row_t                    row_y,
    output batb_pkg::row_t                    row_z,
    output batb_pkg::coord_t                  shift_x,
    output batb_pkg::coord_t                  shift_y,
    output batb_pkg::coord_t                  shift_z
);

    batb_pkg::row_t   row_x_reg, row_y_reg, row_z_reg;
    batb_pkg::coord_t shift_x_reg, shift_y_reg, shift_z_reg;
    batb_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg   <= batb_pkg::RowXReset;
            row_y_reg   <= batb_pkg::RowYReset;
            row_z_reg   <= batb_pkg::RowZReset;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                batb_pkg::RegRowX:   row_x_reg   <= pwdata[batb_pkg::RowW-1:0];
                batb_pkg::RegRowY:   row_y_reg   <= pwdata[batb_pkg::RowW-1:0];
                batb_pkg::RegRowZ:   row_z_reg   <= pwdata[batb_pkg::RowW-1:0];
                batb_pkg::RegShiftX: shift_x_reg <= pwdata[batb_pkg::CoordW-1:0];
                batb_pkg::RegShiftY: shift_y_reg <= pwdata[batb_pkg::CoordW-1:0];
                batb_pkg::RegShiftZ: shift_z_reg <= pwdata[batb_pkg::CoordW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            batb_pkg::RegRowX:   prdata = batb_pkg::DataW'(row_x_reg);
            batb_pkg::RegRowY:   prdata = batb_pkg::DataW'(row_y_reg);
            batb_pkg::RegRowZ:   prdata = batb_pkg::DataW'(row_z_reg);
            batb_pkg::RegShiftX: prdata = batb_pkg::DataW'($unsigned(shift_x_reg));
            batb_pkg::RegShiftY: prdata = batb_pkg::DataW'($unsigned(shift_y_reg));
            batb_pkg::RegShiftZ: prdata = batb_pkg::DataW'($unsigned(shift_z_reg));
            default:             prdata = '0;
        endcase
    end

    assign row_x   = row_x_reg;
    assign row_y   = row_y_reg;
    assign row_z   = row_z_reg;
    assign shift_x = shift_x_reg;
    assign shift_y = shift_y_reg;
    assign shift_z = shift_z_reg;

endmodule
`default_nettype wire

### rtl/core/batb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// batb_ctrl
// Valid bits, stall chain and batch mark for the four datapath stages.
// ============================================================================
module batb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            last_in,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 last_out,
    output batb_pkg::stage_ctl_t ctl
);

    localparam int N = batb_pkg::Stages;

    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] last_reg;
    logic [N:0]   ready;

    // A stage takes new data when it is empty or its successor moves
    always_comb
    begin
        ready[N] = !out_stall;
        for (int k = N - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
            last_reg[0] <= last_in;
        for (int k = 1; k < N; k++)
            if (ready[k])
                last_reg[k] <= last_reg[k-1];
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[N-1];
    assign last_out  = last_reg[N-1];
    assign ctl.load  = ready[N-1:0];
    assign ctl.valid = valid_reg;

endmodule
`default_nettype wire

### rtl/core/batb_row.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// batb_row
// One output axis: products, per-term extremes, sums, scale, offset, clamp.
// ============================================================================
module batb_row (
    input  wire logic                 clk,
    input  wire batb_pkg::stage_ctl_t ctl,
    input  wire batb_pkg::row_t       coeffs,
    input  wire batb_pkg::coord_t     shift,
    input  wire batb_pkg::coord_t     lo_v [3],
    input  wire batb_pkg::coord_t     hi_v [3],
    output batb_pkg::coord_t          res_lo,
    output batb_pkg::coord_t          res_hi
);

    localparam int PW = batb_pkg::ProdW;
    localparam int SW = batb_pkg::SumW;
    localparam int BW = batb_pkg::BiasW;

    logic signed [batb_pkg::CoefW-1:0] coef [3];
    logic signed [PW-1:0] pa_next [3], pb_next [3];
    logic signed [PW-1:0] pa_reg [3], pb_reg [3];
    logic signed [PW-1:0] mn_next [3], mx_next [3];
    logic signed [PW-1:0] mn_reg [3], mx_reg [3];
    logic signed [SW-1:0] smn_next, smx_next, smn_reg, smx_reg;
    logic signed [SW-1:0] qmn, qmx;
    logic signed [BW-1:0] bmn, bmx;
    batb_pkg::coord_t     lo_reg, hi_reg;

    // Stage 0: multiply each coefficient by both box extremes on its axis
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            coef[c]    = $signed(coeffs[batb_pkg::CoefW*c +: batb_pkg::CoefW]);
            pa_next[c] = PW'(coef[c]) * PW'(lo_v[c]);
            pb_next[c] = PW'(coef[c]) * PW'(hi_v[c]);
        end
    end

    // Stage 1: the row sum is separable, so pick each term's extreme
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mn_next[c] = (pa_reg[c] < pb_reg[c]) ? pa_reg[c] : pb_reg[c];
            mx_next[c] = (pa_reg[c] < pb_reg[c]) ? pb_reg[c] : pa_reg[c];
        end
    end

    // Stage 2: sum the extremes
    assign smn_next = SW'(mn_reg[0]) + SW'(mn_reg[1]) + SW'(mn_reg[2]);
    assign smx_next = SW'(mx_reg[0]) + SW'(mx_reg[1]) + SW'(mx_reg[2]);

    // Stage 3: floor scale, add translation, clamp (all monotone)
    assign qmn = smn_reg >>> batb_pkg::FracSh;
    assign qmx = smx_reg >>> batb_pkg::FracSh;
    assign bmn = BW'(qmn) + BW'(shift);
    assign bmx = BW'(qmx) + BW'(shift);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (ctl.load[1])
        begin
            mn_reg <= mn_next;
            mx_reg <= mx_next;
        end
        if (ctl.load[2])
        begin
            smn_reg <= smn_next;
            smx_reg <= smx_next;
        end
        if (ctl.load[3])
        begin
            lo_reg <= batb_pkg::sat_coord(bmn);
            hi_reg <= batb_pkg::sat_coord(bmx);
        end
    end

    assign res_lo = lo_reg;
    assign res_hi = hi_reg;

endmodule
`default_nettype wire

### rtl/core/box_affine_transform_bounds.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// box_affine_transform_bounds
// Encloses an axis-aligned Q16.16 box after a 3x3 Q2.14 matrix and a
// Q16.16 translation, with saturation to the signed 32-bit range.
// ============================================================================
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   ------------------------------------
//  input     in_valid / in_stall         lo_x lo_y lo_z hi_x hi_y hi_z last_in
//  output    out_valid / out_stall       out_lo_* out_hi_* last_out
//  config    APB psel/penable/pready     paddr = 8*index, 64-bit data
//
//  Throughput is one box per cycle while out_stall stays low; a box passes
//  through the four-stage datapath: a 16x32 multiplier per coefficient and
//  box extreme (18 in all), a compare per term, a three-way add, and the
//  scale, offset and clamp stage.
//  Reset clears valid bits, loads the reset matrix (x row takes y, y row
//  takes x, z row scales z by 2^-14) and zero translation.
//  out_stall holds every stage that has no empty slot downstream; bubbles
//  are squeezed out, so in_stall rises only when the whole pipe is full.
//
//  Because the matrix row sum is separable per axis and floor, offset and
//  clamp are monotone, the minimum over eight corners equals the sum of the
//  per-term minima (likewise the maximum); no corner is formed explicitly.
//
module box_affine_transform_bounds (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [batb_pkg::AddrW-1:0]  paddr,
    input  wire logic [batb_pkg::DataW-1:0]  pwdata,
    output logic      [batb_pkg::DataW-1:0]  prdata,
    output logic                             pready,
    // input transactions
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [31:0]          lo_x,
    input  wire logic signed [31:0]          lo_y,
    input  wire logic signed [31:0]          lo_z,
    input  wire logic signed [31:0]          hi_x,
    input  wire logic signed [31:0]          hi_y,
    input  wire logic signed [31:0]          hi_z,
    input  wire logic                        last_in,
    // output transactions
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               out_lo_x,
    output logic signed [31:0]               out_lo_y,
    output logic signed [31:0]               out_lo_z,
    output logic signed [31:0]               out_hi_x,
    output logic signed [31:0]               out_hi_y,
    output logic signed [31:0]               out_hi_z,
    output logic                             last_out
);

    batb_pkg::row_t       row_x, row_y, row_z;
    batb_pkg::coord_t     shift_x, shift_y, shift_z;
    batb_pkg::stage_ctl_t ctl;
    batb_pkg::coord_t     lo_v [3];
    batb_pkg::coord_t     hi_v [3];

    assign lo_v[0] = lo_x;
    assign lo_v[1] = lo_y;
    assign lo_v[2] = lo_z;
    assign hi_v[0] = hi_x;
    assign hi_v[1] = hi_y;
    assign hi_v[2] = hi_z;

    batb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .row_x   (row_x),
        .row_y   (row_y),
        .row_z   (row_z),
        .shift_x (shift_x),
        .shift_y (shift_y),
        .shift_z (shift_z)
    );

    // Valid bits and the stall chain shared by all three axes
    batb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last_out  (last_out),
        .ctl       (ctl)
    );

    // One datapath per output axis; each sees the full input box
    batb_row u_row_x (
        .clk    (clk),
        .ctl    (ctl),
        .coeffs (row_x),
        .shift  (shift_x),
        .lo_v   (lo_v),
        .hi_v   (hi_v),
        .res_lo (out_lo_x),
        .res_hi (out_hi_x)
    );

    batb_row u_row_y (
        .clk    (clk),
        .ctl    (ctl),
        .coeffs (row_y),
        .shift  (shift_y),
        .lo_v   (lo_v),
        .hi_v   (hi_v),
        .res_lo (out_lo_y),
        .res_hi (out_hi_y)
    );

    batb_row u_row_z (
        .clk    (clk),
        .ctl    (ctl),
        .coeffs (row_z),
        .shift  (shift_z),
        .lo_v   (lo_v),
        .hi_v   (hi_v),
        .res_lo (out_lo_z),
        .res_hi (out_hi_z)
    );

endmodule
`default_nettype wire

### rtl/core/batb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// batb_checker
// Port-level checks for the box affine bounds block, bound to the top level.
// ============================================================================
module batb_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [31:0] out_lo_x,
    input wire logic signed [31:0] out_hi_x,
    input wire logic signed [31:0] out_lo_y,
    input wire logic signed [31:0] out_hi_y
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_lo_x) && $stable(out_hi_y))
        else $error("stalled output payload changed");

    // Drain: with no output stall the pipe always has room
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // Advance: an accepted transaction that meets no output stall on its way through the stages reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("accepted transaction did not reach the output");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_lo_x <= out_hi_x) && (out_lo_y <= out_hi_y))
        else $error("output box minimum exceeds maximum");

endmodule

bind box_affine_transform_bounds batb_checker u_batb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_lo_x  (out_lo_x),
    .out_hi_x  (out_hi_x),
    .out_lo_y  (out_lo_y),
    .out_hi_y  (out_hi_y)
);
`default_nettype wire

### bench/box_affine_transform_bounds_test.sv
`timescale 1ns / 1ps
// ============================================================================
// box_affine_transform_bounds_test
// Self-checking bench for the box affine bounds block. A directed list of
// boxes and register writes runs first, followed by random boxes under six
// random transforms. Each expected box is typed in or computed by a predictor,
// and each output transaction is checked in order against the oldest prediction.
// ============================================================================
module box_affine_transform_bounds_test;

    // Indexes past the last register; writes to them must be dropped
    localparam batb_pkg::reg_idx_t RegSpareLo = 3'd6;
    localparam batb_pkg::reg_idx_t RegSpareHi = 3'd7;

    localparam int MaxShown = 10;

    // One box, used for both input and output transactions
    typedef struct packed {
        logic                      last;
        batb_pkg::coord_t [2:0]    hi;
        batb_pkg::coord_t [2:0]    lo;
    } box_t;

    typedef enum logic [1:0] {
        StepReg,
        StepBox,
        StepKnownBox
    } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        batb_pkg::reg_idx_t  reg_idx;
        logic [63:0]         reg_val;
        box_t                box;
        box_t                known;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [batb_pkg::AddrW-1:0]   paddr;
    logic [batb_pkg::DataW-1:0]   pwdata;
    wire  [batb_pkg::DataW-1:0]   prdata;
    wire                          pready;

    logic             in_valid;
    wire              in_stall;
    batb_pkg::coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic             last_in;

    wire    out_valid;
    logic   out_stall;
    wire signed [31:0] out_lo_x, out_lo_y, out_lo_z;
    wire signed [31:0] out_hi_x, out_hi_y, out_hi_z;
    wire    last_out;

    // Transform as the block should hold it
    batb_pkg::row_t coef_rows [3];
    logic [31:0]    offsets   [3];

    box_t        expected_boxes [$];
    step_t       directed_steps [$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    box_affine_transform_bounds dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .lo_x      (lo_x),
        .lo_y      (lo_y),
        .lo_z      (lo_z),
        .hi_x      (hi_x),
        .hi_y      (hi_y),
        .hi_z      (hi_z),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_lo_x  (out_lo_x),
        .out_lo_y  (out_lo_y),
        .out_lo_z  (out_lo_z),
        .out_hi_x  (out_hi_x),
        .out_hi_y  (out_hi_y),
        .out_hi_z  (out_hi_z),
        .last_out  (last_out)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Push all eight corners through the matrix, floor the Q2.14 scale,
    // add the offset, clamp to 32 bits, then keep the per-axis extremes.
    function automatic box_t enclose_transformed(input box_t b);
        box_t               r;
        logic [2:0]         corner;
        logic signed [63:0] pt [3];
        logic signed [63:0] acc;
        logic signed [63:0] w;
        logic signed [63:0] p;
        r = '0;
        r.last = b.last;
        for (int k = 0; k < 8; k++) begin
            corner = 3'(k);
            for (int a = 0; a < 3; a++)
                pt[a] = $signed(corner[a] ? b.hi[a] : b.lo[a]);
            for (int row = 0; row < 3; row++) begin
                acc = '0;
                for (int c = 0; c < 3; c++) begin
                    w = $signed(coef_rows[row][16*c +: 16]);
                    acc = acc + w * pt[c];
                end
                p = (acc >>> batb_pkg::FracSh) + $signed(offsets[row]);
                if (p > batb_pkg::CoordMax)
                    p = batb_pkg::CoordMax;
                else if (p < batb_pkg::CoordMin)
                    p = batb_pkg::CoordMin;
                if (k == 0 || p < $signed(r.lo[row]))
                    r.lo[row] = p[31:0];
                if (k == 0 || p > $signed(r.hi[row]))
                    r.hi[row] = p[31:0];
            end
        end
        return r;
    endfunction

    function automatic string box_text(input box_t b);
        return $sformatf("lo=(%0d,%0d,%0d) hi=(%0d,%0d,%0d) last=%0b",
                         $signed(b.lo[0]), $signed(b.lo[1]), $signed(b.lo[2]),
                         $signed(b.hi[0]), $signed(b.hi[1]), $signed(b.hi[2]),
                         b.last);
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MaxShown)
            $display("[%0t] ERROR %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall, in-order compare against the oldest entry
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : out_monitor
        box_t got;
        box_t want;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            got.lo[0] = out_lo_x;
            got.lo[1] = out_lo_y;
            got.lo[2] = out_lo_z;
            got.hi[0] = out_hi_x;
            got.hi[1] = out_hi_y;
            got.hi[2] = out_hi_z;
            got.last  = last_out;
            if (expected_boxes.size() == 0) begin
                flag_error({"unexpected transaction ", box_text(got)});
            end
            else begin
                want = expected_boxes.pop_front();
                if (got !== want)
                    flag_error({"mismatch\n  expected ", box_text(want),
                                "\n  actual   ", box_text(got)});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic box_t mk_box(input batb_pkg::coord_t lx,
                                    input batb_pkg::coord_t ly,
                                    input batb_pkg::coord_t lz,
                                    input batb_pkg::coord_t hx,
                                    input batb_pkg::coord_t hy,
                                    input batb_pkg::coord_t hz,
                                    input logic lst);
        box_t b;
        b.lo[0] = lx;
        b.lo[1] = ly;
        b.lo[2] = lz;
        b.hi[0] = hx;
        b.hi[1] = hy;
        b.hi[2] = hz;
        b.last  = lst;
        return b;
    endfunction

    task automatic add_reg(input batb_pkg::reg_idx_t idx, input logic [63:0] value);
        step_t s;
        s.kind    = StepReg;
        s.reg_idx = idx;
        s.reg_val = value;
        s.box     = '0;
        s.known   = '0;
        directed_steps.push_back(s);
    endtask

    task automatic add_box(input box_t b);
        step_t s;
        s.kind    = StepBox;
        s.reg_idx = batb_pkg::RegRowX;
        s.reg_val = '0;
        s.box     = b;
        s.known   = '0;
        directed_steps.push_back(s);
    endtask

    task automatic add_known(input box_t b, input box_t want);
        step_t s;
        s.kind    = StepKnownBox;
        s.reg_idx = batb_pkg::RegRowX;
        s.reg_val = '0;
        s.box     = b;
        s.known   = want;
        directed_steps.push_back(s);
    endtask

    // Drop valid and wait until every predicted box has come back
    task automatic drain_boxes();
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_box(input box_t b, input bit typed, input box_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lo_x     <= b.lo[0];
        lo_y     <= b.lo[1];
        lo_z     <= b.lo[2];
        hi_x     <= b.hi[0];
        hi_y     <= b.hi[1];
        hi_z     <= b.hi[2];
        last_in  <= b.last;
        // hold the payload until the transaction is taken
        do
            @(posedge clk);
        while (in_stall);
        expected_boxes.push_back(typed ? want : enclose_transformed(b));
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen high.
    task automatic write_register(input batb_pkg::reg_idx_t idx,
                                  input logic [63:0] value);
        drain_boxes();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            batb_pkg::RegRowX:   coef_rows[0] = value[47:0];
            batb_pkg::RegRowY:   coef_rows[1] = value[47:0];
            batb_pkg::RegRowZ:   coef_rows[2] = value[47:0];
            batb_pkg::RegShiftX: offsets[0]   = value[31:0];
            batb_pkg::RegShiftY: offsets[1]   = value[31:0];
            batb_pkg::RegShiftZ: offsets[2]   = value[31:0];
            default:   ;
        endcase
    endtask

    function automatic batb_pkg::coord_t random_coord();
        batb_pkg::coord_t v;
        case ($urandom_range(3))
            0, 1:    v = $urandom;
            2:       v = int'($urandom_range(1048575)) - 524288;
            default: begin
                case ($urandom_range(4))
                    0:       v = batb_pkg::CoordMin;
                    1:       v = batb_pkg::CoordMax;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 32'sd65536;
                endcase
            end
        endcase
        return v;
    endfunction

    // Mostly ordered boxes, some left inverted on random axes
    function automatic box_t random_box();
        box_t             b;
        batb_pkg::coord_t t;
        for (int a = 0; a < 3; a++) begin
            b.lo[a] = random_coord();
            b.hi[a] = random_coord();
            if ($urandom_range(99) < 70 && $signed(b.lo[a]) > $signed(b.hi[a])) begin
                t       = b.lo[a];
                b.lo[a] = b.hi[a];
                b.hi[a] = t;
            end
        end
        b.last = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic logic [15:0] random_coef(input bit extreme);
        logic [15:0] c;
        if (extreme) begin
            c = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end
        else begin
            case ($urandom_range(3))
                0:       c = 16'($urandom);
                1:       c = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                2:       c = $urandom_range(1) ? 16'h4000 : 16'hC000;
                default: c = 16'h4000 + 16'($urandom_range(511)) - 16'd256;
            endcase
        end
        return c;
    endfunction

    function automatic logic [31:0] random_offset(input bit extreme);
        logic [31:0] v;
        if (extreme) begin
            v = $urandom_range(1) ? batb_pkg::CoordMax : batb_pkg::CoordMin;
        end
        else begin
            case ($urandom_range(2))
                0:       v = $urandom;
                1:       v = int'($urandom_range(4194303)) - 2097152;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // Write all six registers; junk goes into the bits above each register
    task automatic load_random_transform(input bit extreme);
        batb_pkg::reg_idx_t row_regs    [3];
        batb_pkg::reg_idx_t offset_regs [3];
        row_regs    = '{batb_pkg::RegRowX, batb_pkg::RegRowY, batb_pkg::RegRowZ};
        offset_regs = '{batb_pkg::RegShiftX, batb_pkg::RegShiftY, batb_pkg::RegShiftZ};
        for (int r = 0; r < 3; r++)
            write_register(row_regs[r], {16'($urandom), random_coef(extreme),
                                         random_coef(extreme), random_coef(extreme)});
        for (int r = 0; r < 3; r++)
            write_register(offset_regs[r], {32'($urandom), random_offset(extreme)});
    endtask

    // ------------------------------------------------------------------------
    // Directed list
    // ------------------------------------------------------------------------
    // After reset the x row weighs y, the y row weighs x and the z row scales
    // z by 2^-14, so the expected boxes can be typed in directly.
    task automatic build_directed_steps();
        add_known(mk_box(32'sh10000, 32'sh20000, 32'sh30000,
                         32'sh40000, 32'sh50000, 32'sh60000, 1'b0),
                  mk_box(32'sh20000, 32'sh10000, 32'sh0000C,
                         32'sh50000, 32'sh40000, 32'sh00018, 1'b0));
        // full range on every axis
        add_known(mk_box(batb_pkg::CoordMin, batb_pkg::CoordMin, batb_pkg::CoordMin,
                         batb_pkg::CoordMax, batb_pkg::CoordMax, batb_pkg::CoordMax,
                         1'b1),
                  mk_box(batb_pkg::CoordMin, batb_pkg::CoordMin, 32'shFFFE_0000,
                         batb_pkg::CoordMax, batb_pkg::CoordMax, 32'sh0001_FFFF, 1'b1));
        // inverted box: same as with lo and hi swapped
        add_known(mk_box(batb_pkg::CoordMax, 32'sd5, -32'sd1,
                         batb_pkg::CoordMin, -32'sd5, -32'sd16384, 1'b0),
                  mk_box(-32'sd5, batb_pkg::CoordMin, -32'sd1,
                         32'sd5, batb_pkg::CoordMax, -32'sd1, 1'b0));
        add_known(mk_box('0, '0, '0, '0, '0, '0, 1'b1),
                  mk_box('0, '0, '0, '0, '0, '0, 1'b1));
        add_known(mk_box('1, '1, '1, '1, '1, '1, 1'b0),
                  mk_box('1, '1, '1, '1, '1, '1, 1'b0));
        // scaling rounds toward minus infinity
        add_known(mk_box('0, '0, -32'sd16385, '0, '0, 32'sd16383, 1'b1),
                  mk_box('0, '0, -32'sd2, '0, '0, '0, 1'b1));

        // Extreme coefficients and offsets, junk above each register width,
        // and writes to the two unused indexes
        add_reg(batb_pkg::RegRowX,   64'hFFFF_7FFF_7FFF_7FFF);
        add_reg(batb_pkg::RegRowY,   64'h1234_8000_8000_8000);
        add_reg(batb_pkg::RegRowZ,   64'h8000_C000_4000_7FFF);
        add_reg(batb_pkg::RegShiftX, 64'hFFFF_FFFF_7FFF_FFFF);
        add_reg(batb_pkg::RegShiftY, 64'h0000_0001_8000_0000);
        add_reg(batb_pkg::RegShiftZ, 64'hFFFF_FFFF_0001_0000);
        add_reg(RegSpareLo,          64'hFFFF_FFFF_FFFF_FFFF);
        add_reg(RegSpareHi,          64'h0000_0000_0000_0000);
        add_box(mk_box(batb_pkg::CoordMin, batb_pkg::CoordMin, batb_pkg::CoordMin,
                       batb_pkg::CoordMax, batb_pkg::CoordMax, batb_pkg::CoordMax, 1'b1));
        add_box(mk_box(batb_pkg::CoordMax, batb_pkg::CoordMax, batb_pkg::CoordMax,
                       batb_pkg::CoordMax, batb_pkg::CoordMax, batb_pkg::CoordMax, 1'b0));
        add_box(mk_box(batb_pkg::CoordMin, batb_pkg::CoordMin, batb_pkg::CoordMin,
                       batb_pkg::CoordMin, batb_pkg::CoordMin, batb_pkg::CoordMin, 1'b1));
        add_box(mk_box('0, '0, '0, '0, '0, '0, 1'b0));
        add_box(mk_box(32'sh30000, -32'sh10000, 32'sh7FFF,
                       -32'sh20000, 32'sh10000, -32'sh8000, 1'b1));
        add_box(mk_box(32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0,
                       32'sh5555_AAAA, 32'sh2AAA_5555, 32'sh7000_0001, 1'b0));

        // Zero matrix: every output collapses onto the offsets
        add_reg(batb_pkg::RegRowX, 64'h0);
        add_reg(batb_pkg::RegRowY, 64'h0);
        add_reg(batb_pkg::RegRowZ, 64'h0);
        add_known(mk_box(32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 1'b1),
                  mk_box(batb_pkg::CoordMax, batb_pkg::CoordMin, 32'sh10000,
                         batb_pkg::CoordMax, batb_pkg::CoordMin, 32'sh10000, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        lo_x      = '0;
        lo_y      = '0;
        lo_z      = '0;
        hi_x      = '0;
        hi_y      = '0;
        hi_z      = '0;
        last_in   = 1'b0;
        out_stall = 1'b0;
        rst_n     = 1'b0;

        coef_rows[0] = batb_pkg::RowXReset;
        coef_rows[1] = batb_pkg::RowYReset;
        coef_rows[2] = batb_pkg::RowZReset;
        for (int a = 0; a < 3; a++)
            offsets[a] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed list under moderate sender gaps and heavy output stall
        send_idle_pct  = 22;
        recv_stall_pct = 45;
        build_directed_steps();
        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                StepReg:      write_register(directed_steps[i].reg_idx,
                                             directed_steps[i].reg_val);
                StepKnownBox: send_box(directed_steps[i].box, 1'b1, directed_steps[i].known);
                default:      send_box(directed_steps[i].box, 1'b0, '0);
            endcase
        end

        // Random boxes: two transforms per idling profile; in the first and last
        // profiles one of them is built from extreme coefficients and offsets only
        for (int seg = 0; seg < 6; seg++) begin
            load_random_transform(seg == 1 || seg == 4);
            send_idle_pct  = (seg < 2) ? 22 : (seg < 4) ? 45 : 0;
            recv_stall_pct = (seg < 2) ? 45 : (seg < 4) ? 22 : 0;
            repeat (80)
                send_box(random_box(), 1'b0, '0);
        end

        // Let the four-stage pipe empty, then keep watching the output for
        // stray transactions
        drain_boxes();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
